// ===== hdl/dint_pkg.sv =====
// ----------------------------------------------------------------------------
// dint_pkg
// Shared constants for the saturating discrete integrator: register
// indexes, method codes, item function codes, default widths and limit reset values.
// ----------------------------------------------------------------------------
package dint_pkg;

    localparam int unsigned DefSampleWidth = 24;
    localparam int unsigned DefAccWidth    = 32;

    localparam int unsigned CfgIdxWidth  = 3;
    localparam int unsigned CfgDataWidth = 32;
    localparam int unsigned CoefWidth    = 32;
    localparam int unsigned ResultWidth  = 32;

    typedef logic [CfgIdxWidth-1:0] t_cfg_idx;
    typedef logic [1:0]             t_method;

    // configuration register indexes
    localparam t_cfg_idx REG_METHOD       = 3'd0;
    localparam t_cfg_idx REG_COEF_K       = 3'd1;
    localparam t_cfg_idx REG_PARAMS_VALID = 3'd2;
    localparam t_cfg_idx REG_SAT_ENABLE   = 3'd3;
    localparam t_cfg_idx REG_OUT_MIN      = 3'd4;
    localparam t_cfg_idx REG_OUT_MAX      = 3'd5;
    localparam t_cfg_idx REG_INIT_VALUE   = 3'd6;

    // integration methods
    localparam t_method METHOD_FWD_EULER = 2'd0;
    localparam t_method METHOD_BWD_EULER = 2'd1;
    localparam t_method METHOD_TRAPEZOID = 2'd2;

    // item function codes
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_RESET  = 1'b1;

    // limit reset values, Q16.16
    localparam logic signed [ResultWidth-1:0] OutMinReset = 32'sh8000_0000;
    localparam logic signed [ResultWidth-1:0] OutMaxReset = 32'sh7FFF_FFFF;

    function automatic int unsigned f_max(input int unsigned a, input int unsigned b);
        return (a > b) ? a : b;
    endfunction

endpackage

// ===== hdl/discrete_integrator_saturating.sv =====
// pipeline: an accepted item passes the operand, product and output registers on its way to the result
// throughput: one item per cycle while the output is not stalled; the accumulator loop closes inside the last
// stage (round, saturating add and clamp, twice in trapezoidal mode)
// reset: synchronous, active low; state loads zero, limits take their full
// range, all stages empty
// ----------------------------------------------------------------------------
// discrete_integrator_saturating
// Fixed-point integrator (forward/backward Euler, trapezoidal) with
// accumulator saturation and optional output clamping with a flag that marks a result at a limit.
// ----------------------------------------------------------------------------
module discrete_integrator_saturating
    import dint_pkg::*;
#(
    parameter int unsigned SAMPLE_WIDTH = DefSampleWidth,
    parameter int unsigned ACC_WIDTH    = DefAccWidth
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [CfgIdxWidth-1:0]         i_cfg_index,
    input  logic [CfgDataWidth-1:0]        i_cfg_data,
    // input items
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    // result items
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [ResultWidth-1:0]  o_result,
    output logic                           o_saturated
);

    localparam int unsigned PW   = CoefWidth + SAMPLE_WIDTH;      // product
    localparam int unsigned RW   = PW + 1;                        // product plus rounding
    localparam int unsigned ST   = f_max(ACC_WIDTH, ResultWidth); // state width
    localparam int unsigned SUMW = f_max(ST, RW) + 1;

    localparam logic signed [SUMW-1:0] L_ACC_MAX =
        {{(SUMW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
    localparam logic signed [SUMW-1:0] L_ACC_MIN = ~L_ACC_MAX;
    localparam logic signed [RW-1:0] L_HALF24 = {{(RW-24){1'b0}}, 1'b1, {23{1'b0}}};
    localparam logic signed [RW-1:0] L_HALF25 = {{(RW-25){1'b0}}, 1'b1, {24{1'b0}}};

    function automatic logic signed [SUMW-1:0] f_sat(input logic signed [SUMW-1:0] v);
        if (v > L_ACC_MAX) begin
            return L_ACC_MAX;
        end else if (v < L_ACC_MIN) begin
            return L_ACC_MIN;
        end
        return v;
    endfunction

    // out_max wins when the limits cross
    function automatic logic signed [SUMW-1:0] f_clamp(input logic signed [SUMW-1:0] v,
                                                       input logic signed [SUMW-1:0] lo,
                                                       input logic signed [SUMW-1:0] hi);
        logic signed [SUMW-1:0] c;
        c = (v < lo) ? lo : v;
        c = (c > hi) ? hi : c;
        return c;
    endfunction

    // configuration registers
    t_method                        r_method;
    logic signed [CoefWidth-1:0]    r_coef_k;
    logic                           r_params_valid;
    logic                           r_sat_enable;
    logic signed [ResultWidth-1:0]  r_out_min;
    logic signed [ResultWidth-1:0]  r_out_max;
    logic signed [ResultWidth-1:0]  r_init_value;

    // state
    logic signed [ST-1:0]           r_accum,    n_accum;
    logic signed [ST-1:0]           r_out_hold, n_out_hold;
    logic signed [SAMPLE_WIDTH-1:0] r_prev_sample;
    logic                           r_sat_flag, n_sat_flag;

    // pipeline
    logic                           r_v0, r_v1, r_out_valid;
    logic                           r_func0, r_func1;
    logic signed [SAMPLE_WIDTH-1:0] r_operand;
    logic signed [PW-1:0]           r_prod;

    logic                           w_adv;
    logic                           w_accept;
    logic signed [RW-1:0]           w_rsum24, w_rsum25, w_d24, w_h25;
    logic signed [SUMW-1:0]         w_lo, w_hi, w_init_sat;
    logic signed [SUMW-1:0]         w_cfg_init;

    assign w_adv      = !(r_out_valid && i_out_stall);
    assign w_accept   = i_in_valid && w_adv;
    assign o_in_stall = !w_adv;

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out_hold[ResultWidth-1:0];
    assign o_saturated = r_sat_flag;

    assign w_lo       = SUMW'(r_out_min);
    assign w_hi       = SUMW'(r_out_max);
    assign w_init_sat = f_sat(SUMW'(r_init_value));
    assign w_cfg_init = f_sat(SUMW'($signed(i_cfg_data)));

    // rounding half up of k*u to Q16.16 and of k/2*u
    assign w_rsum24 = $signed({r_prod[PW-1], r_prod}) + L_HALF24;
    assign w_rsum25 = $signed({r_prod[PW-1], r_prod}) + L_HALF25;
    assign w_d24    = w_rsum24 >>> 24;
    assign w_h25    = w_rsum25 >>> 25;

    always_comb begin
        logic signed [SUMW-1:0] s1;
        logic signed [SUMW-1:0] s2;
        n_accum    = r_accum;
        n_out_hold = r_out_hold;
        n_sat_flag = r_sat_flag;
        s1         = '0;
        s2         = '0;
        if (r_func1 == FUNC_RESET) begin
            n_accum    = $signed(w_init_sat[ST-1:0]);
            n_out_hold = $signed(w_init_sat[ST-1:0]);
        end else if (r_params_valid) begin
            case (r_method)
                METHOD_FWD_EULER, METHOD_BWD_EULER: begin
                    s1 = f_sat(SUMW'(r_accum) + SUMW'(w_d24));
                    if (r_sat_enable) begin
                        s1         = f_clamp(s1, w_lo, w_hi);
                        n_sat_flag = (s1 >= w_hi) || (s1 <= w_lo);
                    end
                    n_accum    = $signed(s1[ST-1:0]);
                    n_out_hold = $signed(s1[ST-1:0]);
                end
                METHOD_TRAPEZOID: begin
                    s1 = f_sat(SUMW'(r_accum) + SUMW'(w_h25));
                    if (r_sat_enable) begin
                        s1 = f_clamp(s1, w_lo, w_hi);
                    end
                    s2 = f_sat(s1 + SUMW'(w_h25));
                    if (r_sat_enable) begin
                        s2         = f_clamp(s2, w_lo, w_hi);
                        n_sat_flag = (s2 >= w_hi) || (s2 <= w_lo);
                    end
                    n_out_hold = $signed(s1[ST-1:0]);
                    n_accum    = $signed(s2[ST-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // control and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method       <= METHOD_FWD_EULER;
            r_coef_k       <= '0;
            r_params_valid <= 1'b0;
            r_sat_enable   <= 1'b0;
            r_out_min      <= OutMinReset;
            r_out_max      <= OutMaxReset;
            r_init_value   <= '0;
            r_accum        <= '0;
            r_out_hold     <= '0;
            r_prev_sample  <= '0;
            r_sat_flag     <= 1'b0;
            r_v0           <= 1'b0;
            r_v1           <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (w_adv) begin
                r_v0        <= w_accept;
                r_v1        <= r_v0;
                r_out_valid <= r_v1;
            end
            // previous sample follows the item as it enters
            if (w_accept) begin
                if (i_func == FUNC_RESET) begin
                    r_prev_sample <= '0;
                end else if (r_params_valid && r_method == METHOD_FWD_EULER) begin
                    r_prev_sample <= i_sample;
                end
            end
            if (w_adv && r_v1) begin
                r_accum    <= n_accum;
                r_out_hold <= n_out_hold;
                r_sat_flag <= n_sat_flag;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_METHOD:       r_method       <= i_cfg_data[1:0];
                    REG_COEF_K:       r_coef_k       <= $signed(i_cfg_data);
                    REG_PARAMS_VALID: r_params_valid <= i_cfg_data[0];
                    REG_SAT_ENABLE:   r_sat_enable   <= i_cfg_data[0];
                    REG_OUT_MIN:      r_out_min      <= $signed(i_cfg_data);
                    REG_OUT_MAX:      r_out_max      <= $signed(i_cfg_data);
                    REG_INIT_VALUE: begin
                        r_init_value <= $signed(i_cfg_data);
                        r_accum      <= $signed(w_cfg_init[ST-1:0]);
                        r_out_hold   <= $signed(w_cfg_init[ST-1:0]);
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_func0   <= i_func;
            r_operand <= (r_method == METHOD_FWD_EULER) ? r_prev_sample : i_sample;
            r_func1   <= r_func0;
            r_prod    <= r_coef_k * r_operand;
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the saturating discrete integrator. A short table
// of directed items covers the corner cases. Random phases follow, each with
// fresh register settings. Every result is checked against a table value or an
// in-bench integrator model, with random idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import dint_pkg::*;

    localparam int unsigned SampleBits    = DefSampleWidth;
    localparam int unsigned Phases        = 12;
    localparam int unsigned ItemsPerPhase = 120;
    localparam int unsigned DrainCycles   = 6;
    localparam int unsigned HoldCycles    = 80;
    localparam int unsigned HoldAtResult  = 400;
    localparam int unsigned CalmFrom      = 700;
    localparam int unsigned CalmTo        = 900;
    localparam int unsigned CycleLimit    = 200000;

    localparam t_method METHOD_NONE = 2'd3;
    localparam longint  AccMax      = 64'sd2147483647;
    localparam longint  AccMin      = -64'sd2147483648;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        t_cfg_idx              idx;
        logic [31:0]           data;
        logic                  func;
        logic [SampleBits-1:0] sample;
        bit                    typed;
        logic [31:0]           want;
        logic                  want_sat;
    } t_row;

    typedef struct {
        logic [31:0] result;
        logic        saturated;
    } t_integ_out;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    t_cfg_idx                      i_cfg_index = REG_METHOD;
    logic [CfgDataWidth-1:0]       i_cfg_data  = '0;
    logic                          i_in_valid  = 1'b0;
    logic                          i_func      = FUNC_SAMPLE;
    logic signed [SampleBits-1:0]  i_sample    = '0;
    logic                          i_out_stall = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic signed [ResultWidth-1:0] o_result;
    logic                          o_saturated;

    // integrator model: configuration and state
    t_method m_method  = METHOD_FWD_EULER;
    longint  m_coef    = 0;
    logic    m_valid   = 1'b0;
    logic    m_sat_en  = 1'b0;
    longint  m_min     = AccMin;
    longint  m_max     = AccMax;
    longint  m_init    = 0;
    longint  m_accum   = 0;
    longint  m_hold    = 0;
    longint  m_prev    = 0;
    logic    m_flag    = 1'b0;

    t_integ_out pending_results[$];
    t_row       directed[$];
    int         items_sent   = 0;
    int         results_seen = 0;
    int         mismatches   = 0;
    int         cycles       = 0;
    int         hold_left    = 0;
    bit         hold_done    = 1'b0;

    discrete_integrator_saturating u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_sample    (i_sample),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_result    (o_result),
        .o_saturated (o_saturated)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint acc_add(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > AccMax) return AccMax;
        if (s < AccMin) return AccMin;
        return s;
    endfunction

    // Q.40 product down to Q16.16, rounded half up
    function automatic longint scale_round(input longint p, input int unsigned sh);
        return (p + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint clamp_out(input longint v);
        longint c;
        c = v;
        if (!m_sat_en) return c;
        if (c < m_min) c = m_min;
        if (c > m_max) c = m_max;
        m_flag = (c >= m_max) || (c <= m_min);
        return c;
    endfunction

    function automatic t_integ_out integrate_item(input logic f,
                                                  input logic signed [SampleBits-1:0] s);
        longint     u;
        longint     h;
        t_integ_out r;
        u = s;
        if (f == FUNC_RESET) begin
            m_accum = m_init;
            m_hold  = m_accum;
            m_prev  = 0;
        end else if (m_valid) begin
            case (m_method)
                METHOD_FWD_EULER: begin
                    m_accum = clamp_out(acc_add(m_accum, scale_round(m_coef * m_prev, 24)));
                    m_hold  = m_accum;
                    m_prev  = u;
                end
                METHOD_BWD_EULER: begin
                    m_hold  = clamp_out(acc_add(m_accum, scale_round(m_coef * u, 24)));
                    m_accum = m_hold;
                end
                METHOD_TRAPEZOID: begin
                    h       = scale_round(m_coef * u, 25);
                    m_hold  = clamp_out(acc_add(m_accum, h));
                    m_accum = clamp_out(acc_add(m_hold, h));
                end
                default: ;
            endcase
        end
        r.result    = m_hold[31:0];
        r.saturated = m_flag;
        return r;
    endfunction

    function automatic void model_write(input t_cfg_idx idx, input logic [31:0] d);
        case (idx)
            REG_METHOD:       m_method = d[1:0];
            REG_COEF_K:       m_coef   = longint'($signed(d));
            REG_PARAMS_VALID: m_valid  = d[0];
            REG_SAT_ENABLE:   m_sat_en = d[0];
            REG_OUT_MIN:      m_min    = longint'($signed(d));
            REG_OUT_MAX:      m_max    = longint'($signed(d));
            REG_INIT_VALUE: begin
                m_init  = longint'($signed(d));
                m_accum = m_init;
                m_hold  = m_init;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3, 4:    return 32'(int'($urandom_range(524287)) - 262144);
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch on %s at result %0d: got %h, expected %h",
                 what, results_seen, got, want);
        mismatches++;
    endtask

    // called at a falling edge, leaves the write enable high
    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        model_write(idx, d);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic send_item(input logic f, input logic [SampleBits-1:0] s,
                             input bit typed, input t_integ_out want);
        t_integ_out p;
        while (!(items_sent >= CalmFrom && items_sent < CalmTo) &&
               $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_sample   <= s;
        do @(posedge i_clk); while (o_in_stall);
        p = integrate_item(f, s);
        pending_results.push_back(typed ? want : p);
        items_sent++;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : check_results
        t_integ_out w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected item", o_result, 32'h0);
            end else begin
                w = pending_results.pop_front();
                if (o_result !== w.result) report_mismatch("result", o_result, w.result);
                if (o_saturated !== w.saturated)
                    report_mismatch("saturated", 32'(o_saturated), 32'(w.saturated));
            end
        end
    end

    // receiver: random stalls, one long hold-off, and a calm stretch
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left--;
        end else if (!hold_done && results_seen >= HoldAtResult) begin
            hold_done = 1'b1;
            hold_left = HoldCycles - 1;
            i_out_stall <= 1'b1;
        end else if (results_seen >= CalmFrom && results_seen < CalmTo) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 25);
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_integ_out            want;
        logic [SampleBits-1:0] smp;
        logic [31:0]           lo;
        logic [31:0]           hi;
        logic [31:0]           t;
        bit                    in_cfg;

        // kind, index, data, func, sample, typed, result, saturated
        directed = '{
            // parameters not valid after reset: output stays put
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h7FFFFF, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_RESET,  24'h800000, 1'b1, 32'h0, 1'b0},
            '{ROW_CFG,  REG_INIT_VALUE, 32'h7FFF_FFFF, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h000000, 1'b1, 32'h7FFF_FFFF, 1'b0},
            // backward Euler at full scale saturates the accumulator
            '{ROW_CFG,  REG_PARAMS_VALID, 32'd1, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG,  REG_METHOD, 32'(METHOD_BWD_EULER), FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG,  REG_COEF_K, 32'h7FFF_FFFF, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h7FFFFF, 1'b1, 32'h7FFF_FFFF, 1'b0},
            '{ROW_CFG,  REG_INIT_VALUE, 32'h8000_0000, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h800000, 1'b1, 32'h8000_0000, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_RESET,  24'h000000, 1'b1, 32'h8000_0000, 1'b0},
            '{ROW_CFG,  REG_COEF_K, 32'h8000_0000, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h800000, 1'b1, 32'hC000_0000, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h800000, 1'b1, 32'h0000_0000, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h800000, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h800000, 1'b0, 32'h0, 1'b0},
            // forward Euler uses the previous item's sample
            '{ROW_CFG,  REG_METHOD, 32'(METHOD_FWD_EULER), FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG,  REG_INIT_VALUE, 32'h0, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG,  REG_COEF_K, 32'h0100_0000, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h010000, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h020000, 1'b1, 32'h0001_0000, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_RESET,  24'h000000, 1'b1, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h7FFFFF, 1'b1, 32'h0, 1'b0},
            // clamping to -1.0 .. 2.0 with the flag
            '{ROW_CFG,  REG_SAT_ENABLE, 32'd1, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG,  REG_OUT_MIN, 32'hFFFF_0000, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG,  REG_OUT_MAX, 32'h0002_0000, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h800000, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h010000, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h010000, 1'b0, 32'h0, 1'b0},
            // trapezoidal with an odd coefficient exercises the half-step rounding
            '{ROW_CFG,  REG_METHOD, 32'(METHOD_TRAPEZOID), FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG,  REG_COEF_K, 32'h0080_0001, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'hFFFFFF, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h000001, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h7FFFFF, 1'b0, 32'h0, 1'b0},
            // min above max: max wins
            '{ROW_CFG,  REG_OUT_MIN, 32'h0001_0000, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_CFG,  REG_OUT_MAX, 32'h0000_0000, FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h000100, 1'b0, 32'h0, 1'b0},
            // unused method code leaves the state alone
            '{ROW_CFG,  REG_METHOD, 32'(METHOD_NONE), FUNC_SAMPLE, 24'h0, 1'b0, 32'h0, 1'b0},
            '{ROW_ITEM, REG_METHOD, 32'h0, FUNC_SAMPLE, 24'h123456, 1'b0, 32'h0, 1'b0}
        };

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        in_cfg = 1'b0;
        foreach (directed[r]) begin
            if (directed[r].kind == ROW_CFG) begin
                if (!in_cfg) wait_drained();
                in_cfg = 1'b1;
                write_reg(directed[r].idx, directed[r].data);
            end else begin
                if (in_cfg) i_cfg_we <= 1'b0;
                in_cfg = 1'b0;
                want.result    = directed[r].want;
                want.saturated = directed[r].want_sat;
                send_item(directed[r].func, directed[r].sample, directed[r].typed, want);
            end
        end

        want = '{32'h0, 1'b0};
        for (int ph = 0; ph < Phases; ph++) begin
            wait_drained();
            write_reg(REG_METHOD, ($urandom_range(11) == 0) ? 32'(METHOD_NONE)
                                                             : 32'($urandom_range(2)));
            write_reg(REG_PARAMS_VALID, 32'($urandom_range(9) != 0));
            write_reg(REG_SAT_ENABLE, 32'($urandom_range(1)));
            case ($urandom_range(5))
                0:       t = 32'h8000_0000;
                1:       t = 32'h7FFF_FFFF;
                2, 3:    t = 32'(int'($urandom_range(67108863)) - 33554432);
                default: t = $urandom;
            endcase
            write_reg(REG_COEF_K, t);
            if (ph == 0) begin
                lo = OutMinReset;
                hi = OutMaxReset;
            end else begin
                lo = pick_word();
                hi = pick_word();
                // every fifth phase keeps the limits crossed
                if (($signed(lo) > $signed(hi)) != (ph % 5 == 3)) begin
                    t  = lo;
                    lo = hi;
                    hi = t;
                end
            end
            write_reg(REG_OUT_MIN, lo);
            write_reg(REG_OUT_MAX, hi);
            if ($urandom_range(2) != 0) write_reg(REG_INIT_VALUE, pick_word());
            i_cfg_we <= 1'b0;

            for (int n = 0; n < ItemsPerPhase; n++) begin
                case ($urandom_range(9))
                    0:       smp = $urandom_range(1) ? 24'h800000 : 24'h7FFFFF;
                    1, 2:    smp = 24'(int'($urandom_range(131071)) - 65536);
                    default: smp = 24'($urandom);
                endcase
                send_item(($urandom_range(24) == 0) ? FUNC_RESET : FUNC_SAMPLE,
                          smp, 1'b0, want);
            end
        end

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/dint_pkg.sv
hdl/discrete_integrator_saturating.sv
verif/testbench.sv
